>>> hw/rtl/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Setpoint frame deframer package
// Frame layout offsets, register indexes and the result record shared by the
// frame tracker and the top level.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Frame geometry: marker at offset 0, check byte at offset 3.
    localparam int unsigned FRAME_LEN = 12;
    localparam logic [3:0] POS_IDLE   = 4'd0;
    localparam logic [3:0] POS_CHECK  = 4'd3;
    localparam logic [3:0] POS_MODEL  = 4'd4;
    localparam logic [3:0] POS_INPUT  = 4'd5;
    localparam logic [3:0] POS_VALUE  = 4'd8;
    localparam logic [3:0] POS_LAST   = 4'(FRAME_LEN - 1);

    // Configuration register indexes.
    localparam logic CFG_SOF_BYTE   = 1'b0;
    localparam logic CFG_CHECK_SEED = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] SOF_BYTE_RST   = 8'h40;
    localparam logic [7:0] CHECK_SEED_RST = 8'hCA;

    // One decoded setpoint.
    typedef struct packed {
        logic [31:0] setpoint_bits;
        logic [7:0]  input_id;
        logic [7:0]  model_id;
    } t_result;

endpackage

>>> hw/rtl/sfd_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Setpoint frame tracker
// Hunts for the start marker, walks the 12-byte frame one byte per beat,
// folds the XOR check and captures the payload. On the last byte it raises
// a one-cycle result strobe when the check holds.
// ----------------------------------------------------------------------------
module sfd_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_sof_byte,
    input  logic [7:0]        i_check_seed,
    output logic              o_res_valid,
    output sfd_pkg::t_result  o_res
);
    import sfd_pkg::*;

    logic [3:0]  r_pos,     n_pos;
    logic [7:0]  r_acc,     n_acc;
    logic [7:0]  r_check,   n_check;
    logic [7:0]  r_model,   n_model;
    logic [7:0]  r_input,   n_input;
    logic [31:0] r_setp,    n_setp;
    logic        w_hunting;

    // Offsets past the end of the frame cannot occur; they count as idle.
    assign w_hunting = (r_pos == POS_IDLE) || (r_pos > POS_LAST);

    // Next-state logic for one received byte.
    always_comb begin
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_check = r_check;
        n_model = r_model;
        n_input = r_input;
        n_setp  = r_setp;
        if (i_beat) begin
            if (w_hunting) begin
                if (i_byte == i_sof_byte) begin
                    n_acc = i_check_seed ^ i_byte;
                    n_pos = 4'd1;
                end else begin
                    n_pos = POS_IDLE;
                end
            end else begin
                if (r_pos == POS_CHECK) begin
                    n_check = i_byte;
                end else begin
                    n_acc = r_acc ^ i_byte;
                end
                if (r_pos == POS_MODEL) begin
                    n_model = i_byte;
                end
                if (r_pos == POS_INPUT) begin
                    n_input = i_byte;
                end
                // Setpoint bytes land in the lane given by the low offset bits.
                if (r_pos >= POS_VALUE) begin
                    case (r_pos[1:0])
                        2'd0:    n_setp[7:0]   = i_byte;
                        2'd1:    n_setp[15:8]  = i_byte;
                        2'd2:    n_setp[23:16] = i_byte;
                        default: n_setp[31:24] = i_byte;
                    endcase
                end
                n_pos = (r_pos == POS_LAST) ? POS_IDLE : r_pos + 4'd1;
            end
        end
    end

    // The last byte completes both the check and the top setpoint byte.
    assign o_res_valid = i_beat && !w_hunting && (r_pos == POS_LAST) &&
                         ((r_acc ^ i_byte) == r_check);
    assign o_res.model_id      = r_model;
    assign o_res.input_id      = r_input;
    assign o_res.setpoint_bits = {i_byte, r_setp[23:0]};

    // Frame position is control state; the rest is only read inside a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_check <= n_check;
        r_model <= n_model;
        r_input <= n_input;
        r_setp  <= n_setp;
    end

endmodule

>>> hw/rtl/setpoint_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Setpoint frame deframer
// Turns a stream of received serial bytes into checked setpoint records.
//
//   Channel   Dir  Beat contents (low bit first)
//   s_axis    in   tdata[7:0] rx_byte
//   m_axis    out  tdata[7:0] model_id, [15:8] input_id,
//                  [47:16] setpoint_bits
//   cfg       in   index 0 sof_byte, index 1 check_seed (8-bit data)
//
// One byte is taken per cycle; the last frame byte's result is registered
// at the output. Reset is synchronous: the block hunts for a marker and the
// registers return to 0x40 and 0xCA. A stalled output holds its beat and a
// skid register takes one more result, so input stops only when both fill.
// ----------------------------------------------------------------------------
module setpoint_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Config write port.
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    // Byte stream in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    // Setpoint stream out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [7:0] model_id, [15:8] input_id,
                                       // [47:16] setpoint_bits
);
    import sfd_pkg::*;

    logic [7:0] r_sof_byte;
    logic [7:0] r_check_seed;
    logic       w_beat;
    logic       w_res_valid;
    t_result    w_res;
    logic       r_out_valid, n_out_valid;
    logic       r_skid_valid, n_skid_valid;
    t_result    r_out, n_out;
    t_result    r_skid, n_skid;
    logic       w_out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof_byte   <= SOF_BYTE_RST;
            r_check_seed <= CHECK_SEED_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SOF_BYTE:   r_sof_byte   <= i_cfg_wdata;
                CFG_CHECK_SEED: r_check_seed <= i_cfg_wdata;
                default:        r_check_seed <= r_check_seed;
            endcase
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign w_beat        = s_axis_tvalid && s_axis_tready;

    sfd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (w_beat),
        .i_byte       (s_axis_tdata),
        .i_sof_byte   (r_sof_byte),
        .i_check_seed (r_check_seed),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    // Output register with a skid stage behind it.
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = w_res;
                n_skid_valid = w_res_valid;
            end else begin
                n_out        = w_res;
                n_out_valid  = w_res_valid;
            end
        end else if (w_res_valid) begin
            n_skid       = w_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTH
    // The skid register is only ever filled behind a held output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    // A result appears only on an accepted byte.
    a_res_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_beat)
        else $error("frame tracker produced a result without an input beat");

    // A result that arrives while the output is stalled fills the skid.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid && w_res_valid && r_out_valid && !m_axis_tready)
        |=> (r_skid_valid && r_out_valid))
        else $error("result lost while the output was stalled");
`endif

endmodule
